/* rtl/b32enc_pkg.sv */
// shared types, constants and checksum functions for the bech32 string encoder
`timescale 1ns / 1ps

package b32enc_pkg;

  localparam int unsigned SymW  = 5;
  localparam int unsigned ChkW  = 30;
  localparam int unsigned CharW = 7;
  localparam int unsigned BufW  = 12;
  localparam int unsigned CntW  = 4;
  localparam int unsigned IdxW  = 3;

  localparam logic [ChkW-1:0] GenTab [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [7:0] HrpText [5] = '{8'h6c, 8'h6e, 8'h75, 8'h72, 8'h6c};

  typedef enum logic [2:0] {
    CHK_HOLD,
    CHK_INIT,
    CHK_FOLD,
    CHK_FOLD_FINAL,
    CHK_SHIFT
  } chk_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_DATA,
    ST_PAD,
    ST_ZERO,
    ST_CHK
  } state_e;

  typedef struct packed {
    chk_op_e           op;
    logic [SymW-1:0]   sym;
  } chk_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [CharW-1:0]  ch;
    logic              last;
  } emit_t;

  // one polymod step: shift in a 5-bit symbol, reduce by the generator
  function automatic logic [ChkW-1:0] fold(input logic [ChkW-1:0] chk,
                                           input logic [SymW-1:0] sym);
    logic [ChkW-1:0] r;
    r = {chk[ChkW-SymW-1:0], sym};
    for (int i = 0; i < 5; i++) begin
      if (chk[ChkW-SymW+i]) begin
        r = r ^ GenTab[i];
      end
    end
    return r;
  endfunction

  // polymod over the expanded "lnurl" part
  function automatic logic [ChkW-1:0] start_chk();
    logic [ChkW-1:0] c;
    c = 30'd1;
    for (int i = 0; i < 5; i++) begin
      c = fold(c, {2'b00, HrpText[i][7:5]});
    end
    c = fold(c, 5'd0);
    for (int i = 0; i < 5; i++) begin
      c = fold(c, HrpText[i][4:0]);
    end
    return c;
  endfunction

  localparam logic [ChkW-1:0] StartChk = start_chk();

  function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] s);
    logic [CharW-1:0] c;
    case (s)
      5'd0:    c = 7'h51; // Q
      5'd1:    c = 7'h50; // P
      5'd2:    c = 7'h5a; // Z
      5'd3:    c = 7'h52; // R
      5'd4:    c = 7'h59; // Y
      5'd5:    c = 7'h39; // 9
      5'd6:    c = 7'h58; // X
      5'd7:    c = 7'h38; // 8
      5'd8:    c = 7'h47; // G
      5'd9:    c = 7'h46; // F
      5'd10:   c = 7'h32; // 2
      5'd11:   c = 7'h54; // T
      5'd12:   c = 7'h56; // V
      5'd13:   c = 7'h44; // D
      5'd14:   c = 7'h57; // W
      5'd15:   c = 7'h30; // 0
      5'd16:   c = 7'h53; // S
      5'd17:   c = 7'h33; // 3
      5'd18:   c = 7'h4a; // J
      5'd19:   c = 7'h4e; // N
      5'd20:   c = 7'h35; // 5
      5'd21:   c = 7'h34; // 4
      5'd22:   c = 7'h4b; // K
      5'd23:   c = 7'h48; // H
      5'd24:   c = 7'h43; // C
      5'd25:   c = 7'h45; // E
      5'd26:   c = 7'h36; // 6
      5'd27:   c = 7'h4d; // M
      5'd28:   c = 7'h55; // U
      5'd29:   c = 7'h41; // A
      5'd30:   c = 7'h37; // 7
      default: c = 7'h4c; // L
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] prefix_char(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      3'd0:    c = 7'h4c; // L
      3'd1:    c = 7'h4e; // N
      3'd2:    c = 7'h55; // U
      3'd3:    c = 7'h52; // R
      3'd4:    c = 7'h4c; // L
      default: c = 7'h31; // 1
    endcase
    return c;
  endfunction

endpackage

/* rtl/b32enc_chk.sv */
// bech32 polymod checksum register, one symbol folded per cycle when commanded, held otherwise
`timescale 1ns / 1ps

module b32enc_chk
  import b32enc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  chk_cmd_t        cmd_i,
  output logic [SymW-1:0] top_sym_o
);

  logic [ChkW-1:0] chk_q, chk_d;

  always_comb begin
    chk_d = chk_q;
    case (cmd_i.op)
      CHK_HOLD:       chk_d = chk_q;
      CHK_INIT:       chk_d = StartChk;
      CHK_FOLD:       chk_d = fold(chk_q, cmd_i.sym);
      CHK_FOLD_FINAL: chk_d = fold(chk_q, '0) ^ {{(ChkW-1){1'b0}}, 1'b1};
      CHK_SHIFT:      chk_d = {chk_q[ChkW-SymW-1:0], {SymW{1'b0}}};
      default:        chk_d = chk_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q <= StartChk;
    end else begin
      chk_q <= chk_d;
    end
  end

  assign top_sym_o = chk_q[ChkW-1:ChkW-SymW];

endmodule

/* rtl/b32enc_ctrl.sv */
// sequencer: prefix, 5-bit regrouping shift register, padding and checksum readout
`timescale 1ns / 1ps

module b32enc_ctrl
  import b32enc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic            adv_i,
  input  logic [SymW-1:0] chk_sym_i,
  output chk_cmd_t        chk_cmd_o,
  output emit_t           emit_o
);

  state_e          state_q, state_d;
  logic [BufW-1:0] buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            at_start_q, at_start_d;
  logic            last_q, last_d;
  logic [CntW-1:0] cnt_nx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign cnt_nx     = cnt_q - CntW'(SymW);

  always_comb begin
    state_d       = state_q;
    buf_d         = buf_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    at_start_d    = at_start_q;
    last_d        = last_q;
    chk_cmd_o.op  = CHK_HOLD;
    chk_cmd_o.sym = buf_q[BufW-1:BufW-SymW];
    emit_o.valid  = 1'b0;
    emit_o.ch     = sym_char(buf_q[BufW-1:BufW-SymW]);
    emit_o.last   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // pending bits sit left-aligned, the new byte goes right behind them
          buf_d  = buf_q | ({data_byte_i, 4'b0000} >> cnt_q);
          cnt_d  = cnt_q + CntW'(8);
          last_d = last_byte_i;
          idx_d  = '0;
          state_d = at_start_q ? ST_PREFIX : ST_DATA;
        end
      end
      ST_PREFIX: begin
        emit_o.ch = prefix_char(idx_q);
        if (adv_i) begin
          emit_o.valid = 1'b1;
          idx_d        = idx_q + IdxW'(1);
          if (idx_q == IdxW'(5)) begin
            at_start_d = 1'b0;
            state_d    = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (adv_i) begin
          emit_o.valid = 1'b1;
          chk_cmd_o.op = CHK_FOLD;
          buf_d        = {buf_q[BufW-SymW-1:0], {SymW{1'b0}}};
          cnt_d        = cnt_nx;
          idx_d        = '0;
          if (cnt_nx < CntW'(SymW)) begin
            if (!last_q) begin
              state_d = ST_IDLE;
            end else if (cnt_nx != '0) begin
              state_d = ST_PAD;
            end else begin
              state_d = ST_ZERO;
            end
          end
        end
      end
      ST_PAD: begin
        // leftover bits are already left-aligned over zeros
        if (adv_i) begin
          emit_o.valid = 1'b1;
          chk_cmd_o.op = CHK_FOLD;
          buf_d        = '0;
          cnt_d        = '0;
          idx_d        = '0;
          state_d      = ST_ZERO;
        end
      end
      ST_ZERO: begin
        chk_cmd_o.sym = '0;
        idx_d         = idx_q + IdxW'(1);
        if (idx_q == IdxW'(5)) begin
          chk_cmd_o.op = CHK_FOLD_FINAL;
          idx_d        = '0;
          state_d      = ST_CHK;
        end else begin
          chk_cmd_o.op = CHK_FOLD;
        end
      end
      ST_CHK: begin
        emit_o.ch   = sym_char(chk_sym_i);
        emit_o.last = (idx_q == IdxW'(5));
        if (adv_i) begin
          emit_o.valid = 1'b1;
          chk_cmd_o.op = CHK_SHIFT;
          idx_d        = idx_q + IdxW'(1);
          if (idx_q == IdxW'(5)) begin
            chk_cmd_o.op = CHK_INIT;
            buf_d        = '0;
            cnt_d        = '0;
            at_start_d   = 1'b1;
            last_d       = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      buf_q      <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
      at_start_q <= 1'b1;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      at_start_q <= at_start_d;
      last_q     <= last_d;
    end
  end

endmodule

/* rtl/bech32_stream_encoder.sv */
// top level of the streaming bech32 encoder with the fixed lnurl prefix
`timescale 1ns / 1ps

// Takes message bytes one request at a time (last_byte_i on the final one) and
// streams out the uppercase bech32 string "LNURL1" + data + checksum, one ASCII
// character per output request, last_char_o set on the sixth checksum character.
// The byte is taken while the sequencer is idle, then its one or two 5-bit
// symbols leave one per cycle while the output register can take them, through
// the regrouping shift register and the polymod register; the prefix comes at the
// start of a string, and the end adds the padded symbol, the zero folding and
// 6 checksum characters. An output register decouples the output stall.

module bech32_stream_encoder
  import b32enc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] out_char_o,
  output logic             last_char_o
);

  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic             last_char_q;
  logic             adv;
  chk_cmd_t         chk_cmd;
  logic [SymW-1:0]  chk_sym;
  emit_t            emit;

  // the sequencer may produce a character when the output register frees up
  assign adv = !out_valid_q || !out_stall_i;

  b32enc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .adv_i       (adv),
    .chk_sym_i   (chk_sym),
    .chk_cmd_o   (chk_cmd),
    .emit_o      (emit)
  );

  b32enc_chk u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (chk_cmd),
    .top_sym_o (chk_sym)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit.valid) begin
      out_char_q  <= emit.ch;
      last_char_q <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_char_q;

endmodule

/* tb/testbench.sv */
// self-checking bench for the lnurl bech32 stream encoder: directed and random byte messages
`timescale 1ns / 1ps

module testbench;
  import b32enc_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       fin;
    int         gap;
    bit         hold;
  } msg_req_t;

  typedef struct {
    logic [CharW-1:0] ch;
    logic             fin;
  } enc_char_t;

  // uppercase bech32 alphabet, symbol 0 in the top byte
  localparam logic [8*32-1:0] ALPHABET = "QPZRY9X8GF2TVDW0S3JN54KHCE6MUA7L";
  localparam logic [8*6-1:0]  PREFIX   = "LNURL1";
  localparam logic [8*5-1:0]  HRP      = "lnurl";
  localparam logic [ChkW-1:0] POLY_GEN [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             last_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] out_char;
  logic             last_char;

  msg_req_t  msg_q[$];
  enc_char_t string_q[$];
  int        errors = 0;
  int        bytes_sent = 0;
  int        bytes_taken = 0;

  // encoder model state
  logic [ChkW-1:0] poly_acc;
  logic [11:0]     spare_bits;
  int              spare_cnt;
  bit              need_prefix;

  bech32_stream_encoder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .data_byte_i (data_byte),
    .last_byte_i (last_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_char_o  (out_char),
    .last_char_o (last_char)
  );

  function automatic logic [ChkW-1:0] polymod_step(input logic [ChkW-1:0] c,
                                                   input logic [4:0] s);
    logic [ChkW-1:0] r;
    r = {c[24:0], s};
    for (int i = 0; i < 5; i++) begin
      if (c[25+i]) begin
        r = r ^ POLY_GEN[i];
      end
    end
    return r;
  endfunction

  function automatic logic [ChkW-1:0] hrp_polymod();
    logic [ChkW-1:0] c;
    logic [7:0]      h;
    c = 30'd1;
    for (int i = 0; i < 5; i++) begin
      h = HRP[8*(4-i) +: 8];
      c = polymod_step(c, {2'b00, h[7:5]});
    end
    c = polymod_step(c, 5'd0);
    for (int i = 0; i < 5; i++) begin
      h = HRP[8*(4-i) +: 8];
      c = polymod_step(c, h[4:0]);
    end
    return c;
  endfunction

  function automatic logic [CharW-1:0] alpha_char(input logic [4:0] s);
    logic [7:0] b;
    b = ALPHABET[8*(31-s) +: 8];
    return b[CharW-1:0];
  endfunction

  task automatic restart_string();
    poly_acc    = hrp_polymod();
    spare_bits  = '0;
    spare_cnt   = 0;
    need_prefix = 1'b1;
  endtask

  task automatic push_char(input logic [CharW-1:0] ch, input logic fin);
    enc_char_t e;
    e.ch  = ch;
    e.fin = fin;
    string_q.insert(string_q.size(), e);
  endtask

  task automatic push_symbol(input logic [4:0] s);
    push_char(alpha_char(s), 1'b0);
    poly_acc = polymod_step(poly_acc, s);
  endtask

  // chars that one accepted byte produces
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [11:0]     acc;
    logic [11:0]     tmp;
    logic [ChkW-1:0] c;
    logic [7:0]      pch;
    int              n;
    if (need_prefix) begin
      for (int i = 0; i < 6; i++) begin
        pch = PREFIX[8*(5-i) +: 8];
        push_char(pch[CharW-1:0], 1'b0);
      end
      need_prefix = 1'b0;
    end
    acc = (spare_bits << 8) | {4'h0, b};
    n = spare_cnt + 8;
    while (n >= 5) begin
      n = n - 5;
      tmp = acc >> n;
      push_symbol(tmp[4:0]);
    end
    acc = acc & ((12'd1 << n) - 12'd1);
    if (!fin) begin
      spare_bits = acc;
      spare_cnt  = n;
    end else begin
      // zero-padded tail symbol
      if (n > 0) begin
        tmp = acc << (5 - n);
        push_symbol(tmp[4:0]);
      end
      c = poly_acc;
      for (int i = 0; i < 6; i++) begin
        c = polymod_step(c, 5'd0);
      end
      c = c ^ 30'd1;
      for (int i = 0; i < 6; i++) begin
        push_char(alpha_char(c[5*(5-i) +: 5]), i == 5);
      end
      restart_string();
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin, input bit calm);
    msg_req_t r;
    r.data = b;
    r.fin  = fin;
    r.gap  = calm ? 0 : $urandom_range(0, 13);
    r.hold = 1'b0;
    msg_q.insert(msg_q.size(), r);
    bytes_sent++;
  endtask

  task automatic queue_hold();
    msg_req_t r;
    r.data = '0;
    r.fin  = 1'b0;
    r.gap  = 0;
    r.hold = 1'b1;
    msg_q.insert(msg_q.size(), r);
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // sender
  always @(posedge clk or negedge rst_n) begin : send_p
    logic     nxt_valid;
    msg_req_t head;
    int       gap_left;
    bit       gap_armed;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      data_byte <= 8'h00;
      last_byte <= 1'b0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, last_byte);
        bytes_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && msg_q.size() > 0) begin
        if (msg_q[0].hold) begin
          // let the whole output drain before going on
          if (string_q.size() == 0) begin
            void'(msg_q.pop_front());
          end
        end else begin
          if (!gap_armed) begin
            gap_left  = msg_q[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            head = msg_q.pop_front();
            data_byte <= head.data;
            last_byte <= head.fin;
            nxt_valid = 1'b1;
            gap_armed = 1'b0;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // receiver and checker
  always @(posedge clk or negedge rst_n) begin : recv_p
    enc_char_t want;
    int        stall_left;
    bit        calm;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      calm       = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (string_q.size() == 0) begin
          $display("%0t: unexpected char, actual %h last %b", $time, out_char, last_char);
          errors++;
        end else begin
          want = string_q.pop_front();
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
            errors++;
          end
          if (last_char !== want.fin) begin
            $display("%0t: last_char expected %b actual %b", $time, want.fin, last_char);
            errors++;
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 23) == 0) begin
          calm = !calm;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim_p
    int  len;
    bit  calm;
    bit  held;
    logic [7:0] b;
    restart_string();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte strings at both extremes, then lengths that leave
    // every possible count of leftover bits before padding
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hff, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hff, 1'b1, 1'b1);
    queue_byte(8'hff, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'haa, 1'b1, 1'b0);
    queue_byte(8'h55, 1'b0, 1'b1);
    queue_byte(8'haa, 1'b0, 1'b1);
    queue_byte(8'h01, 1'b0, 1'b1);
    queue_byte(8'h80, 1'b1, 1'b1);
    for (int i = 0; i < 5; i++) begin
      queue_byte(8'hff, i == 4, 1'b0);
    end
    queue_hold();

    held = 1'b0;
    while (bytes_sent < 136) begin
      calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = 8'($urandom_range(0, 255));
        endcase
        queue_byte(b, i == len - 1, calm);
      end
      if (!held && bytes_sent > 90) begin
        queue_hold();
        held = 1'b1;
      end
    end

    while (bytes_taken < bytes_sent) @(posedge clk);
    while (string_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/b32enc_pkg.sv
rtl/b32enc_chk.sv
rtl/b32enc_ctrl.sv
rtl/bech32_stream_encoder.sv
tb/testbench.sv
